// ----- hdl/dttfp_pkg.sv -----
package dttfp_pkg;

  localparam int CHAR_W         = 8;
  localparam int VALUE_W        = 64;
  localparam int MANT_W         = 64;
  localparam int DIGIT_W        = 4;
  localparam int COUNT_W        = 5;
  localparam int FRAC_BITS_DEF  = 32;
  localparam int MAX_DIGITS_DEF = 19;
  // 10^31 < 2^103
  localparam int POW_W          = 103;

  localparam logic [COUNT_W-1:0] AFTER_POINT_MAX = 5'd31;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [VALUE_W-1:0] SAT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SAT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic start_div;
    logic div_step;
    logic round;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_term;
    logic out_free;
  } dp_status_t;

  function automatic logic [POW_W-1:0] pow10(input logic [COUNT_W-1:0] n);
    logic [POW_W-1:0] p;
    unique case (n)
      5'd0:  p = 103'd1;
      5'd1:  p = 103'd10;
      5'd2:  p = 103'd100;
      5'd3:  p = 103'd1_000;
      5'd4:  p = 103'd10_000;
      5'd5:  p = 103'd100_000;
      5'd6:  p = 103'd1_000_000;
      5'd7:  p = 103'd10_000_000;
      5'd8:  p = 103'd100_000_000;
      5'd9:  p = 103'd1_000_000_000;
      5'd10: p = 103'd10_000_000_000;
      5'd11: p = 103'd100_000_000_000;
      5'd12: p = 103'd1_000_000_000_000;
      5'd13: p = 103'd10_000_000_000_000;
      5'd14: p = 103'd100_000_000_000_000;
      5'd15: p = 103'd1_000_000_000_000_000;
      5'd16: p = 103'd10_000_000_000_000_000;
      5'd17: p = 103'd100_000_000_000_000_000;
      5'd18: p = 103'd1_000_000_000_000_000_000;
      5'd19: p = 103'd10_000_000_000_000_000_000;
      5'd20: p = 103'd100_000_000_000_000_000_000;
      5'd21: p = 103'd1_000_000_000_000_000_000_000;
      5'd22: p = 103'd10_000_000_000_000_000_000_000;
      5'd23: p = 103'd100_000_000_000_000_000_000_000;
      5'd24: p = 103'd1_000_000_000_000_000_000_000_000;
      5'd25: p = 103'd10_000_000_000_000_000_000_000_000;
      5'd26: p = 103'd100_000_000_000_000_000_000_000_000;
      5'd27: p = 103'd1_000_000_000_000_000_000_000_000_000;
      5'd28: p = 103'd10_000_000_000_000_000_000_000_000_000;
      5'd29: p = 103'd100_000_000_000_000_000_000_000_000_000;
      5'd30: p = 103'd1_000_000_000_000_000_000_000_000_000_000;
      5'd31: p = 103'd10_000_000_000_000_000_000_000_000_000_000;
      default: p = 103'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/decimal_text_to_fixed_point.sv -----
// Input: other bytes one beat per cycle while idle; a terminator holds the input
// through the one-bit-per-cycle restoring divider (65 + FRAC_BITS steps), the
// round state and the emit state, which waits for a free output register; the
// result then stands in the output register.
// Reset: rst_n synchronous, active low; clears the parser, controller and output valid.
module decimal_text_to_fixed_point
  import dttfp_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // text in, one byte a beat
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [CHAR_W-1:0]         in_tdata,   // [7:0] character
  // fixed-point result
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic signed [VALUE_W-1:0] out_tdata,  // [63:0] result_value
  output logic                      out_tuser   // [0] overflow
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: takes bytes while idle, then walks the divider, rounding
  // and emit steps for a terminator; emit waits for the output register.
  dttfp_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: parser state, mantissa shift-add, power-of-ten table,
  // restoring divider for mantissa * 2^FRAC_BITS / 10^n with a half bit
  // for rounding, saturation, sign and the output register.
  dttfp_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hdl/dttfp_ctrl.sv -----
module dttfp_ctrl
  import dttfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int Q_W   = MANT_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        count_nxt = '0;
        if (in_tvalid && status.is_term) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == LAST_STEP) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.take_byte = in_tvalid;
        cmd.start_div = in_tvalid && status.is_term;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_ROUND:  cmd.round    = 1'b1;
      ST_EMIT:   cmd.emit     = status.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/dttfp_datapath.sv -----
module dttfp_datapath
  import dttfp_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic [CHAR_W-1:0]         in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic signed [VALUE_W-1:0] out_tdata,
  output logic                      out_tuser
);

  localparam int Q_W = MANT_W + FRAC_BITS + 1;
  localparam logic [COUNT_W-1:0] DIGIT_LIMIT = COUNT_W'(MAX_DIGITS);

  // parse state
  logic               in_body_r, in_body_nxt;
  logic               neg_r, neg_nxt;
  logic [MANT_W-1:0]  mant_r, mant_nxt;
  logic [COUNT_W-1:0] sig_r, sig_nxt;
  logic               seen_r, seen_nxt;
  logic [COUNT_W-1:0] dap_r, dap_nxt;
  logic               drop_r, drop_nxt;

  // divider
  logic [POW_W-1:0]   pow_r, pow_nxt;
  logic [POW_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]     quo_r, quo_nxt;
  logic [Q_W-1:0]     mag_r, mag_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_data_r, out_data_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic [CHAR_W-1:0]  char_off;
  logic [DIGIT_W-1:0] digit;
  logic               is_ws, is_digit, is_sign;
  logic               leading_zero;
  logic [POW_W:0]     rem_sh;
  logic [POW_W:0]     rem_diff;
  logic               rem_ge;
  logic [Q_W-1:0]     limit_w;
  logic               sat;
  logic [VALUE_W-1:0] mag_v;

  assign char_off = in_tdata - CHAR_ZERO;
  assign digit    = char_off[DIGIT_W-1:0];
  assign is_ws    = (in_tdata >= CHAR_TAB && in_tdata <= CHAR_CR) || in_tdata == CHAR_SPACE;
  assign is_digit = in_tdata >= CHAR_ZERO && in_tdata <= CHAR_NINE;
  assign is_sign  = in_tdata == CHAR_PLUS || in_tdata == CHAR_MINUS;
  assign leading_zero = (mant_r == '0) && (digit == '0);

  assign status.is_term  = in_tdata == CHAR_NUL;
  assign status.out_free = !out_valid_r || out_tready;

  // one restoring step
  assign rem_sh   = {rem_r, quo_r[Q_W-1]};
  assign rem_diff = rem_sh - {1'b0, pow_r};
  assign rem_ge   = rem_sh >= {1'b0, pow_r};

  assign limit_w = Q_W'(neg_r ? SAT_NEG : SAT_POS);
  assign sat     = mag_r > limit_w;
  assign mag_v   = sat ? limit_w[VALUE_W-1:0] : mag_r[VALUE_W-1:0];

  always_comb begin
    in_body_nxt = in_body_r;
    neg_nxt     = neg_r;
    mant_nxt    = mant_r;
    sig_nxt     = sig_r;
    seen_nxt    = seen_r;
    dap_nxt     = dap_r;
    drop_nxt    = drop_r;

    if (cmd.take_byte && !status.is_term) begin
      if (in_body_r || !is_ws) begin
        in_body_nxt = 1'b1;
        if (!in_body_r && is_sign) begin
          neg_nxt = in_tdata == CHAR_MINUS;
        end else if (is_digit) begin
          if (!(seen_r && dap_r >= AFTER_POINT_MAX)) begin
            if (!leading_zero && sig_r >= DIGIT_LIMIT) begin
              // no room: an integer digit lost is an overflow
              if (!seen_r) begin
                drop_nxt = 1'b1;
              end
            end else begin
              if (!leading_zero) begin
                mant_nxt = (mant_r << 3) + (mant_r << 1) + MANT_W'(digit);
                sig_nxt  = sig_r + COUNT_W'(1);
              end
              if (seen_r) begin
                dap_nxt = dap_r + COUNT_W'(1);
              end
            end
          end
        end else if (in_tdata == CHAR_POINT) begin
          seen_nxt = 1'b1;
          dap_nxt  = '0;
        end
      end
    end

    if (cmd.emit) begin
      in_body_nxt = 1'b0;
      neg_nxt     = 1'b0;
      mant_nxt    = '0;
      sig_nxt     = '0;
      seen_nxt    = 1'b0;
      dap_nxt     = '0;
      drop_nxt    = 1'b0;
    end
  end

  always_comb begin
    pow_nxt = pow_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    mag_nxt = mag_r;
    if (cmd.start_div) begin
      pow_nxt = pow10(dap_r);
      rem_nxt = '0;
      quo_nxt = {mant_r, (FRAC_BITS + 1)'(0)};
    end else if (cmd.div_step) begin
      rem_nxt = rem_ge ? rem_diff[POW_W-1:0] : rem_sh[POW_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], rem_ge};
    end
    if (cmd.round) begin
      // lowest quotient bit is the half bit
      mag_nxt = (quo_r >> 1) + Q_W'(quo_r[0]);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = neg_r ? (~mag_v + VALUE_W'(1)) : mag_v;
      out_ovf_nxt   = drop_r || sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r   <= 1'b0;
      neg_r       <= 1'b0;
      mant_r      <= '0;
      sig_r       <= '0;
      seen_r      <= 1'b0;
      dap_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_body_r   <= in_body_nxt;
      neg_r       <= neg_nxt;
      mant_r      <= mant_nxt;
      sig_r       <= sig_nxt;
      seen_r      <= seen_nxt;
      dap_r       <= dap_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r      <= pow_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    mag_r      <= mag_nxt;
    out_data_r <= out_data_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ----- dv/decimal_text_to_fixed_point_checker.sv -----
`timescale 1ns / 100ps
module decimal_text_to_fixed_point_checker
  import dttfp_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [CHAR_W-1:0]         in_tdata,   // [7:0] character
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic signed [VALUE_W-1:0] out_tdata,  // [63:0] result_value
  input  logic                      out_tuser,  // [0] overflow
  output int                        fail_count,
  output int                        results_owed
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
  } fixed_result_t;

  fixed_result_t owed_q[$];
  fixed_result_t want;

  // parser state
  logic               text_in_body;
  logic               is_negative;
  logic               point_seen;
  logic               int_digit_lost;
  logic [MANT_W-1:0]  digit_acc;
  logic [COUNT_W-1:0] sig_digits;
  logic [COUNT_W-1:0] places;

  function automatic void clear_parse();
    text_in_body   = 1'b0;
    is_negative    = 1'b0;
    point_seen     = 1'b0;
    int_digit_lost = 1'b0;
    digit_acc      = '0;
    sig_digits     = '0;
    places         = '0;
  endfunction

  // One text byte in; a terminator queues the scaled, rounded, saturated value.
  function automatic void absorb_char(input logic [CHAR_W-1:0] c);
    logic [127:0]       scale;
    logic [127:0]       quo;
    logic [127:0]       rem;
    logic [127:0]       limit;
    logic [DIGIT_W-1:0] d;
    fixed_result_t      r;
    if (c == CHAR_NUL) begin
      scale = 128'd1;
      for (int i = 0; i < places; i++) scale = scale * 10;
      quo = {64'd0, digit_acc} << FRAC_BITS;
      rem = quo % scale;
      quo = quo / scale;
      // round half away from zero on the magnitude
      if ((rem << 1) >= scale) quo = quo + 128'd1;
      limit = is_negative ? (128'd1 << (VALUE_W - 1)) : ((128'd1 << (VALUE_W - 1)) - 128'd1);
      r.overflow = int_digit_lost;
      if (quo > limit) begin
        quo        = limit;
        r.overflow = 1'b1;
      end
      r.value = is_negative ? -quo[VALUE_W-1:0] : quo[VALUE_W-1:0];
      owed_q.push_back(r);
      clear_parse();
      return;
    end
    if (!text_in_body) begin
      if ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE) return;
      text_in_body = 1'b1;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        is_negative = (c == CHAR_MINUS);
        return;
      end
    end
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c[DIGIT_W-1:0];  // ASCII digits carry their value in the low nibble
      if (point_seen && places >= AFTER_POINT_MAX) return;
      if (!(digit_acc == '0 && d == '0)) begin
        if (sig_digits >= MAX_DIGITS) begin
          if (!point_seen) int_digit_lost = 1'b1;
          return;
        end
        digit_acc  = digit_acc * 10 + d;
        sig_digits = sig_digits + 1'b1;
      end
      if (point_seen) places = places + 1'b1;
    end else if (c == CHAR_POINT) begin
      point_seen = 1'b1;
      places     = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      owed_q.delete();
      fail_count = 0;
    end else begin
      // result side first: a result never belongs to a terminator of the same edge
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h/%b", $time, out_tdata,
                   out_tuser);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.value) begin
            $display("%0t: result_value expected %h, got %h", $time, want.value, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.overflow) begin
            $display("%0t: overflow expected %b, got %b", $time, want.overflow, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) absorb_char(in_tdata);
    end
    results_owed <= owed_q.size();
  end

endmodule

// ----- dv/decimal_text_to_fixed_point_test.sv -----
`timescale 1ns / 100ps
module decimal_text_to_fixed_point_test;
  import dttfp_pkg::*;

  localparam int FRAC_BITS  = FRAC_BITS_DEF;
  localparam int MAX_DIGITS = MAX_DIGITS_DEF;

  localparam int TEXT_BYTES   = 1850;            // stimulus stops once this many beats went in
  localparam int LONG_HOLD    = 400;             // one long receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = FRAC_BITS + 72;  // terminator latency plus margin
  // slowest quiet spell: the long hold plus a full divide, taken many times over
  localparam int IDLE_LIMIT   = 4000;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [CHAR_W-1:0]         in_tdata   = '0;     // [7:0] character
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic signed [VALUE_W-1:0] out_tdata;            // [63:0] result_value
  logic                      out_tuser;            // [0] overflow

  int                fail_count;
  int                results_owed;
  logic [CHAR_W-1:0] text_buf[$];   // one string under construction, no terminator
  int                bytes_sent    = 0;
  bit                long_hold_req = 1'b0;
  int                idle_cycles   = 0;

  decimal_text_to_fixed_point #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Watches both channels, predicts every terminator's result and counts mismatches.
  decimal_text_to_fixed_point_checker #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic load_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Random digit run; zeros are favoured so leading zeros turn up often.
  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++)
      text_buf.push_back(($urandom_range(3) == 0) ? CHAR_ZERO
                                                  : CHAR_ZERO + CHAR_W'($urandom_range(9)));
  endtask

  // Mostly short runs, some mid-length, a few long enough to hit the digit limits.
  function automatic int draw_len(input int longest);
    int r;
    r = $urandom_range(9);
    if (r < 7) return $urandom_range(6);
    if (r < 9) return $urandom_range(15, 7);
    return $urandom_range(longest, 16);
  endfunction

  // Sends the buffered string and its terminator, one beat at a time.
  // A calm string goes out back to back; otherwise each beat may be held back by a random gap first.
  task automatic send_text(input bit calm);
    int gap;
    text_buf.push_back(CHAR_NUL);
    foreach (text_buf[i]) begin
      gap = calm ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= text_buf[i];
      do @(posedge clk); while (!in_tready);
      bytes_sent++;
    end
    text_buf.delete();
  endtask

  // Stimulus and verdict.
  initial begin
    int                kind;
    int                pos;
    int                c;
    logic [CHAR_W-1:0] stray;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings
    send_text(1'b0);                                    // empty text
    for (c = CHAR_TAB; c <= CHAR_CR; c++) text_buf.push_back(CHAR_W'(c));
    text_buf.push_back(CHAR_SPACE);
    send_text(1'b1);                                    // whitespace only
    load_str(" +7");             send_text(1'b0);
    load_str("-12.5-+");         send_text(1'b1);       // late signs ignored
    load_str("000.00100");       send_text(1'b0);       // leading zeros after the point
    load_str("-0.0");            send_text(1'b0);       // negative zero
    load_str("1.2.75");          send_text(1'b1);       // last point sets the scale
    load_str("2147483647.9999999999"); send_text(1'b0); // 20th digit dropped, stays below the top
    load_str("-2147483648");     send_text(1'b0);       // most negative, still exact
    load_str("123456789012345678901"); send_text(1'b1); // integer digits dropped
    load_str("0.00000000000000000000000000000001234");  // fraction past 31 places
    send_text(1'b0);
    text_buf.push_back(8'hFF);                          // top bits of the byte, as noise
    text_buf.push_back(8'h80);
    text_buf.push_back(8'h01);
    load_str("3");
    send_text(1'b0);

    // receiver now holds off once for a long spell while text keeps coming
    long_hold_req = 1'b1;

    while (bytes_sent < TEXT_BYTES) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        // pure noise string
        repeat ($urandom_range(8)) text_buf.push_back(CHAR_W'($urandom_range(255, 1)));
      end else begin
        repeat ($urandom_range(2))
          text_buf.push_back($urandom_range(1) ? CHAR_SPACE
                                               : CHAR_W'($urandom_range(CHAR_CR, CHAR_TAB)));
        case ($urandom_range(2))
          1:       text_buf.push_back(CHAR_PLUS);
          2:       text_buf.push_back(CHAR_MINUS);
          default: ;
        endcase
        add_digits(draw_len(24));
        if ($urandom_range(2) != 0) begin
          text_buf.push_back(CHAR_POINT);
          add_digits(draw_len(36));
        end
        if (kind == 1) begin
          // broken string: a stray point, sign or random byte somewhere inside
          case ($urandom_range(2))
            0:       stray = CHAR_POINT;
            1:       stray = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
            default: stray = CHAR_W'($urandom_range(255, 1));
          endcase
          pos = $urandom_range(text_buf.size());
          text_buf.insert(pos, stray);
        end
      end
      send_text($urandom_range(3) == 0);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("decimal_text_to_fixed_point_test: clean");
    end else begin
      $display("decimal_text_to_fixed_point_test: errors");
    end
    $finish;
  end

  // Result side: a random stall before each beat, calm spells with none,
  // and the one long hold-off that backs the block up into its input.
  initial begin
    int stall;
    int calm_left;
    calm_left = 0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(6);
        if ($urandom_range(7) == 0) calm_left = 12;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("decimal_text_to_fixed_point_test: errors");
      $finish;
    end
  end

endmodule
